@@ hdl/f64x_pkg.sv @@
// Shared constants, types and helper functions for the f64 / f80 format converter.
package f64x_pkg;

	// Format constants
	localparam int EXT_BIAS      = 16383;
	localparam int DBL_BIAS      = 1023;
	localparam int EXT_EXP_MAX   = 32767;
	localparam int DBL_FRAC_BITS = 52;
	localparam int DBL_EXP_BITS  = 11;
	localparam int DBL_EXP_MAX   = (1 << DBL_EXP_BITS) - 1;

	// Rebias offset between the two exponent fields
	localparam int BIAS_DIFF      = EXT_BIAS - DBL_BIAS;
	// Extended exponent of a normalized double subnormal with no leading zeros
	localparam int SUB_EXP_BASE   = BIAS_DIFF + 1;
	// Right shift for an extended value in double subnormal range is this minus e
	localparam int SUB_SHIFT_BASE = BIAS_DIFF + DBL_EXP_BITS + 1;
	// Highest extended exponent that still flushes to zero
	localparam int FLUSH_EXP_MAX  = BIAS_DIFF - DBL_FRAC_BITS;
	// Lowest extended exponent that saturates to infinity
	localparam int INF_EXP_MIN    = BIAS_DIFF + DBL_EXP_MAX;

	// Operation codes
	typedef enum logic {
		OP_D2E = 1'b0,
		OP_E2D = 1'b1
	} op_t;

	// Class of a word; bit 3 set means extended to double
	typedef enum logic [3:0] {
		K_D2E_ZERO = 4'h0,
		K_D2E_SUB  = 4'h1,
		K_D2E_SPEC = 4'h2,
		K_D2E_NORM = 4'h3,
		K_E2D_ZERO = 4'h8,
		K_E2D_NAN  = 4'h9,
		K_E2D_INF  = 4'hA,
		K_E2D_SUB  = 4'hB,
		K_E2D_NORM = 4'hC
	} kind_t;

	// Word between pipeline stages
	typedef struct packed {
		kind_t       kind;
		logic        sign;
		logic [5:0]  sh;
		logic [63:0] mant;
		logic [10:0] exp;
	} stage_t;

	// Leading-zero count of a nonzero 64-bit value, binary search in six steps
	function automatic logic [5:0] lead_zeros(logic [63:0] v);
		logic [63:0] t;
		logic [5:0]  n;
		t = v;
		n = '0;
		if (t[63:32] == 32'd0) begin n[5] = 1'b1; t = {t[31:0], 32'd0}; end
		if (t[63:48] == 16'd0) begin n[4] = 1'b1; t = {t[47:0], 16'd0}; end
		if (t[63:56] == 8'd0) begin n[3] = 1'b1; t = {t[55:0], 8'd0}; end
		if (t[63:60] == 4'd0) begin n[2] = 1'b1; t = {t[59:0], 4'd0}; end
		if (t[63:62] == 2'd0) begin n[1] = 1'b1; t = {t[61:0], 2'd0}; end
		if (t[63] == 1'b0) begin n[0] = 1'b1; end
		return n;
	endfunction

endpackage

@@ hdl/f64x_format_converter_unit.sv @@
// Top level of the f64 / f80 format converter: three-stage pipeline and checks.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one word: operation, mantissa_in
//   and sign_exponent_in. Operation 0 turns an IEEE double pattern into an x87
//   extended significand and sign/exponent word; operation 1 turns an extended
//   value into a double pattern, truncating, with sign_exponent_out zero.
//   Output channel (out_valid / out_ready) carries mantissa_out and
//   sign_exponent_out, in input order.
//   A word passes three registers in order: classify with leading-zero count
//   into stage 1 at acceptance, one barrel shift into stage 2, then exponent
//   math and packing into the output register, which drives out_valid.
//   Throughput is one word per cycle while out_ready stays high.
//   Reset clears the three stage valid bits only; the pipeline is then empty.
//   When the receiver stalls, a full stage holds its word while empty stages
//   ahead of it keep filling, so in_ready drops only once all three stages
//   hold words and out_ready is low.
module f64_f80_format_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [63:0] mantissa_in,
	input  logic [15:0] sign_exponent_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] mantissa_out,
	output logic [15:0] sign_exponent_out
);

	f64x_pkg::stage_t data_s1;
	f64x_pkg::stage_t data_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             ready_s2;
	logic             ready_s3;

	// Stage 1: decode
	f64x_classify u_classify (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.mantissa_in      (mantissa_in),
		.sign_exponent_in (sign_exponent_in),
		.dn_ready         (ready_s2),
		.valid_s1         (valid_s1),
		.data_s1          (data_s1)
	);

	// Stage 2: shift
	f64x_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_ready (ready_s2),
		.up_data  (data_s1),
		.dn_ready (ready_s3),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	// Stage 3: pack into output register
	f64x_pack u_pack (
		.clk              (clk),
		.arst_n           (arst_n),
		.up_valid         (valid_s2),
		.up_ready         (ready_s3),
		.up_data          (data_s2),
		.dn_ready         (out_ready),
		.valid_s3         (out_valid),
		.mantissa_s3      (mantissa_out),
		.sign_exponent_s3 (sign_exponent_out)
	);

	// Checks
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted with full pipeline stalled");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted word missing from stage 1");

	a_e2d_se_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ready_s3 && data_s2.kind[3]) |=> (sign_exponent_out == 16'd0))
		else $error("extended to double word has nonzero sign/exponent");

	a_d2e_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (sign_exponent_out[14:0] != 15'd0)) |-> mantissa_out[63])
		else $error("extended result with nonzero exponent lacks integer bit");

endmodule

@@ hdl/f64x_classify.sv @@
// Stage 1: field decode, case classification and shift count.
module f64x_classify (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [63:0]          mantissa_in,
	input  logic [15:0]          sign_exponent_in,
	input  logic                 dn_ready,
	output logic                 valid_s1,
	output f64x_pkg::stage_t     data_s1
);

	f64x_pkg::stage_t st;
	logic [10:0] e_d;
	logic [63:0] m_d;
	logic [14:0] e_x;

	assign e_d = mantissa_in[62:52];
	assign m_d = {mantissa_in[51:0], 11'd0};
	assign e_x = sign_exponent_in[14:0];

	// Decode and classify the incoming word
	always_comb begin
		if (operation == f64x_pkg::OP_D2E) begin
			st.sign = mantissa_in[63];
			st.mant = m_d;
			st.exp  = e_d;
			st.sh   = f64x_pkg::lead_zeros(m_d);
			if (e_d == 11'd0) begin
				st.kind = (m_d == 64'd0) ? f64x_pkg::K_D2E_ZERO : f64x_pkg::K_D2E_SUB;
			end else if (e_d == 11'(f64x_pkg::DBL_EXP_MAX)) begin
				st.kind = f64x_pkg::K_D2E_SPEC;
			end else begin
				st.kind = f64x_pkg::K_D2E_NORM;
			end
		end else begin
			st.sign = sign_exponent_in[15];
			st.mant = mantissa_in;
			st.exp  = 11'(e_x - 15'(f64x_pkg::BIAS_DIFF));
			st.sh   = 6'(15'(f64x_pkg::SUB_SHIFT_BASE) - e_x);
			if (e_x == 15'd0) begin
				st.kind = f64x_pkg::K_E2D_ZERO;
			end else if (e_x == 15'(f64x_pkg::EXT_EXP_MAX)) begin
				st.kind = f64x_pkg::K_E2D_NAN;
			end else if (e_x <= 15'(f64x_pkg::FLUSH_EXP_MAX)) begin
				st.kind = f64x_pkg::K_E2D_ZERO;
			end else if (e_x <= 15'(f64x_pkg::BIAS_DIFF)) begin
				st.kind = f64x_pkg::K_E2D_SUB;
			end else if (e_x >= 15'(f64x_pkg::INF_EXP_MIN)) begin
				st.kind = f64x_pkg::K_E2D_INF;
			end else begin
				st.kind = f64x_pkg::K_E2D_NORM;
			end
		end
	end

	// Stage register: moves when empty or when the next stage takes it
	assign in_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= st;
		end
	end

endmodule

@@ hdl/f64x_align.sv @@
// Stage 2: normalize shift for double subnormals, denormalize shift for extended values in double subnormal range.
module f64x_align (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  f64x_pkg::stage_t     up_data,
	input  logic                 dn_ready,
	output logic                 valid_s2,
	output f64x_pkg::stage_t     data_s2
);

	f64x_pkg::stage_t st;

	// One barrel shift, direction chosen by class
	always_comb begin
		st = up_data;
		case (up_data.kind)
			f64x_pkg::K_D2E_SUB: st.mant = up_data.mant << up_data.sh;
			f64x_pkg::K_E2D_SUB: st.mant = up_data.mant >> up_data.sh;
			default:             st.mant = up_data.mant;
		endcase
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= st;
		end
	end

endmodule

@@ hdl/f64x_pack.sv @@
// Stage 3: exponent arithmetic and packing of the result word into the output register.
module f64x_pack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  f64x_pkg::stage_t     up_data,
	input  logic                 dn_ready,
	output logic                 valid_s3,
	output logic [63:0]          mantissa_s3,
	output logic [15:0]          sign_exponent_s3
);

	logic [63:0] mo;
	logic [15:0] so;
	logic [51:0] nan_frac;
	logic        nan_lost;

	// NaN payload: keep bits 62..11, force to one if only lower bits were set
	assign nan_frac = up_data.mant[62:11];
	assign nan_lost = (nan_frac == 52'd0) && (up_data.mant[62:0] != 63'd0);

	// Assemble the result word
	always_comb begin
		mo = '0;
		so = '0;
		case (up_data.kind)
			f64x_pkg::K_D2E_ZERO: begin
				so = {up_data.sign, 15'd0};
			end
			f64x_pkg::K_D2E_SUB: begin
				mo = up_data.mant;
				so = {up_data.sign,
					15'(f64x_pkg::SUB_EXP_BASE) - {9'd0, up_data.sh}};
			end
			f64x_pkg::K_D2E_SPEC: begin
				mo = {1'b1, up_data.mant[62:0]};
				so = {up_data.sign, 15'(f64x_pkg::EXT_EXP_MAX)};
			end
			f64x_pkg::K_D2E_NORM: begin
				mo = {1'b1, up_data.mant[62:0]};
				so = {up_data.sign, 15'(f64x_pkg::BIAS_DIFF) + {4'd0, up_data.exp}};
			end
			f64x_pkg::K_E2D_ZERO: begin
				mo = {up_data.sign, 63'd0};
			end
			f64x_pkg::K_E2D_NAN: begin
				mo = {up_data.sign, 11'(f64x_pkg::DBL_EXP_MAX),
					nan_lost ? 52'd1 : nan_frac};
			end
			f64x_pkg::K_E2D_INF: begin
				mo = {up_data.sign, 11'(f64x_pkg::DBL_EXP_MAX), 52'd0};
			end
			f64x_pkg::K_E2D_SUB: begin
				mo = {up_data.sign, 11'd0, up_data.mant[51:0]};
			end
			f64x_pkg::K_E2D_NORM: begin
				mo = {up_data.sign, up_data.exp, up_data.mant[62:11]};
			end
			default: begin
				mo = '0;
				so = '0;
			end
		endcase
	end

	assign up_ready = !valid_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			mantissa_s3      <= mo;
			sign_exponent_s3 <= so;
		end
	end

endmodule

@@ verif/tb_f64_f80_format_converter_unit.sv @@
// Self-checking testbench for the double / x87 extended format converter unit.
`timescale 1ns / 1ps

module tb_f64_f80_format_converter_unit;

	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_PER_PHASE = 220;

	// One input word and one converted result
	typedef struct {
		f64x_pkg::op_t op;
		logic [63:0]   mant;
		logic [15:0]   se;
	} conv_word_t;

	typedef struct {
		logic [63:0] mant;
		logic [15:0] se;
	} conv_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = 1'b0;
	logic [63:0] mantissa_in = '0;
	logic [15:0] sign_exponent_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] mantissa_out;
	logic [15:0] sign_exponent_out;

	conv_word_t   pending_words[$];
	conv_result_t results_due[$];
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  stall_pct = 0;

	f64_f80_format_converter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.mantissa_in(mantissa_in),
		.sign_exponent_in(sign_exponent_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mantissa_out(mantissa_out),
		.sign_exponent_out(sign_exponent_out)
	);

	always #5 clk = ~clk;

	// Expected conversion of one word
	function automatic conv_result_t convert_word(f64x_pkg::op_t op, logic [63:0] m,
		logic [15:0] se);
		conv_result_t r;
		logic [10:0]  de;
		logic [63:0]  sig;
		logic [63:0]  ef;
		logic [63:0]  fr;
		int           xe;
		int           rb;
		int           lz;
		r = '{mant: '0, se: '0};
		if (op == f64x_pkg::OP_D2E) begin
			de = m[62:52];
			sig = {1'b0, m[51:0], 11'd0};
			if (de == 11'd0) begin
				// zero keeps exponent 0; subnormal is normalized by leading zeros
				if (sig != 64'd0) begin
					lz = 0;
					while (!sig[63]) begin
						sig = sig << 1;
						lz++;
					end
					xe = f64x_pkg::EXT_BIAS - f64x_pkg::DBL_BIAS + 1 - lz;
				end else begin
					xe = 0;
				end
			end else if (de == 11'(f64x_pkg::DBL_EXP_MAX)) begin
				sig[63] = 1'b1;
				xe = f64x_pkg::EXT_EXP_MAX;
			end else begin
				sig[63] = 1'b1;
				xe = int'(de) + f64x_pkg::EXT_BIAS - f64x_pkg::DBL_BIAS;
			end
			r.mant = sig;
			r.se = {m[63], xe[14:0]};
		end else begin
			xe = int'(se[14:0]);
			ef = '0;
			fr = '0;
			if (xe == f64x_pkg::EXT_EXP_MAX) begin
				// inf or NaN; a NaN whose kept bits are all zero still stays a NaN
				ef = 64'(f64x_pkg::DBL_EXP_MAX);
				fr = {12'd0, m[62:11]};
				if (fr == 64'd0 && m[62:0] != 63'd0)
					fr = 64'd1;
			end else if (xe != 0) begin
				rb = xe + f64x_pkg::DBL_BIAS - f64x_pkg::EXT_BIAS;
				if (rb <= -f64x_pkg::DBL_FRAC_BITS) begin
					fr = '0;
				end else if (rb <= 0) begin
					fr = m >> (12 - rb);
				end else if (rb >= f64x_pkg::DBL_EXP_MAX) begin
					ef = 64'(f64x_pkg::DBL_EXP_MAX);
				end else begin
					ef = 64'(rb);
					fr = {12'd0, m[62:11]};
				end
			end
			r.mant = {se[15], 63'd0} + (ef << f64x_pkg::DBL_FRAC_BITS) + fr;
			r.se = '0;
		end
		return r;
	endfunction

	task automatic push_word(f64x_pkg::op_t op, logic [63:0] m, logic [15:0] se);
		conv_word_t w;
		w.op = op;
		w.mant = m;
		w.se = se;
		pending_words.push_back(w);
	endtask

	// Driver: predicts on acceptance, then presents the next word unless idling
	always @(posedge clk or negedge arst_n) begin
		conv_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= 1'b0;
			mantissa_in <= '0;
			sign_exponent_in <= '0;
		end else begin
			if (in_valid && in_ready)
				results_due.push_back(convert_word(f64x_pkg::op_t'(operation),
					mantissa_in, sign_exponent_in));
			if (!in_valid || in_ready) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					operation <= w.op;
					mantissa_in <= w.mant;
					sign_exponent_in <= w.se;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		conv_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected word mant %h se %h", $realtime,
							mantissa_out, sign_exponent_out);
				end else begin
					exp_r = results_due.pop_front();
					if (mantissa_out !== exp_r.mant || sign_exponent_out !== exp_r.se) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch exp mant %h se %h, got mant %h se %h",
								$realtime, exp_r.mant, exp_r.se, mantissa_out,
								sign_exponent_out);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_f64_f80_format_converter_unit NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: directed words, then random words over four phases of input idling and output stalling
	initial begin
		int unsigned idle_tab[4];
		int unsigned stall_tab[4];
		int          ph;
		int          i;
		int          xe;
		logic [63:0] m;
		logic [15:0] se;
		logic [10:0] de;
		logic [51:0] fr;
		idle_tab = '{0, 72, 0, 21};
		stall_tab = '{0, 0, 72, 21};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// double to extended: zeros, subnormal ends, specials, normal ends
		push_word(f64x_pkg::OP_D2E, 64'h0000_0000_0000_0000, 16'h0000);
		push_word(f64x_pkg::OP_D2E, 64'h8000_0000_0000_0000, 16'hFFFF);
		push_word(f64x_pkg::OP_D2E, 64'h0000_0000_0000_0001, 16'h0000);
		push_word(f64x_pkg::OP_D2E, 64'h000F_FFFF_FFFF_FFFF, 16'h8001);
		push_word(f64x_pkg::OP_D2E, 64'h8000_0800_0000_0000, 16'h7FFF);
		push_word(f64x_pkg::OP_D2E, 64'h7FF0_0000_0000_0000, 16'h0000);
		push_word(f64x_pkg::OP_D2E, 64'hFFF8_0000_0000_0001, 16'h0000);
		push_word(f64x_pkg::OP_D2E, 64'h7FF0_0000_0000_0001, 16'h0000);
		push_word(f64x_pkg::OP_D2E, 64'h0010_0000_0000_0000, 16'h0000);
		push_word(f64x_pkg::OP_D2E, 64'h7FEF_FFFF_FFFF_FFFF, 16'h0000);
		push_word(f64x_pkg::OP_D2E, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		// extended to double: zero and denormal, inf, NaN kept and forced
		push_word(f64x_pkg::OP_E2D, 64'h0000_0000_0000_0000, 16'h0000);
		push_word(f64x_pkg::OP_E2D, 64'h0000_0000_FFFF_FFFF, 16'h8000);
		push_word(f64x_pkg::OP_E2D, 64'h8000_0000_0000_0000, 16'hFFFF);
		push_word(f64x_pkg::OP_E2D, 64'h8000_0000_0000_0001, 16'h7FFF);
		push_word(f64x_pkg::OP_E2D, 64'hC000_0000_0000_0000, 16'h7FFF);
		push_word(f64x_pkg::OP_E2D, 64'h0000_0000_0000_0400, 16'hFFFF);
		// unnormal, flush boundary, subnormal range ends, overflow boundary
		push_word(f64x_pkg::OP_E2D, 64'h4000_0000_0000_0000, 16'h3FFF);
		push_word(f64x_pkg::OP_E2D, 64'hFFFF_FFFF_FFFF_FFFF,
			16'(f64x_pkg::BIAS_DIFF - 52));
		push_word(f64x_pkg::OP_E2D, 64'hFFFF_FFFF_FFFF_FFFF,
			16'(f64x_pkg::BIAS_DIFF - 51));
		push_word(f64x_pkg::OP_E2D, 64'h8000_0000_0000_0000,
			16'(f64x_pkg::BIAS_DIFF));
		push_word(f64x_pkg::OP_E2D, 64'h8000_0000_0000_0000,
			16'(f64x_pkg::BIAS_DIFF + 1));
		push_word(f64x_pkg::OP_E2D, 64'hFFFF_FFFF_FFFF_FFFF,
			16'(f64x_pkg::BIAS_DIFF + 2046));
		push_word(f64x_pkg::OP_E2D, 64'hFFFF_FFFF_FFFF_FFFF,
			16'(f64x_pkg::BIAS_DIFF + 2047));
		push_word(f64x_pkg::OP_E2D, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFE);

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			for (i = 0; i < RANDOM_PER_PHASE; i++) begin
				if ($urandom_range(1) == 0) begin
					// double pattern by class; the sign/exponent input is ignored
					se = 16'($urandom);
					fr = 52'({$urandom, $urandom});
					case ($urandom_range(9))
						0: de = 11'd0;
						1, 2: begin
							de = 11'd0;
							fr = (fr | 52'h8_0000_0000_0000) >> $urandom_range(51);
						end
						3: begin
							de = 11'(f64x_pkg::DBL_EXP_MAX);
							if ($urandom_range(1) == 0)
								fr = '0;
						end
						4: de = ($urandom_range(1) == 0) ? 11'd1 :
							11'(f64x_pkg::DBL_EXP_MAX - 1);
						default: de = 11'($urandom_range(f64x_pkg::DBL_EXP_MAX));
					endcase
					if (de == 11'd0 && $urandom_range(19) == 0)
						fr = '0;
					m = {1'($urandom_range(1)), de, fr};
					push_word(f64x_pkg::OP_D2E, m, se);
				end else begin
					// extended value: exponent near every boundary, assorted significands
					case ($urandom_range(9))
						0: xe = 0;
						1: xe = f64x_pkg::EXT_EXP_MAX;
						2, 3: xe = $urandom_range(f64x_pkg::BIAS_DIFF + 4,
							f64x_pkg::BIAS_DIFF - 60);
						4: xe = $urandom_range(f64x_pkg::INF_EXP_MIN + 5,
							f64x_pkg::INF_EXP_MIN - 7);
						5: xe = $urandom_range(f64x_pkg::EXT_EXP_MAX - 1, 1);
						default: xe = $urandom_range(f64x_pkg::INF_EXP_MIN - 1,
							f64x_pkg::BIAS_DIFF + 1);
					endcase
					m = {$urandom, $urandom};
					case ($urandom_range(7))
						0: m = '0;
						1: m = m >> $urandom_range(63);
						2: m = {1'b1, 52'd0, m[10:0]};
						3, 4: m[63] = 1'b1;
						default: ;
					endcase
					se = {1'($urandom_range(1)), 15'(xe)};
					push_word(f64x_pkg::OP_E2D, m, se);
				end
			end
			while (pending_words.size() != 0 || in_valid)
				@(negedge clk);
		end

		// drain, then allow the pipeline latency to pass
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("tb_f64_f80_format_converter_unit OK");
		end else begin
			$display("tb_f64_f80_format_converter_unit NOT OK");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/f64x_pkg.sv
hdl/f64x_classify.sv
hdl/f64x_align.sv
hdl/f64x_pack.sv
hdl/f64x_format_converter_unit.sv
verif/tb_f64_f80_format_converter_unit.sv
